// ===== src/iip_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iip_pkg: constants and calendar helpers for the ISO-8601 instant parser
// Day offsets, digit limits and the month tables used by the day-number path.
// ----------------------------------------------------------------------------
package iip_pkg;

	// Field and result widths
	localparam int unsigned CHAR_W   = 8;
	localparam int unsigned DAY_W    = 23;
	localparam int unsigned MS_W     = 27;
	localparam int unsigned YEAR_W   = 14;
	localparam int unsigned ACC_W    = 7;
	localparam int unsigned MILLI_W  = 10;
	localparam int unsigned FD_W     = 4;
	localparam int unsigned YDAYS_W  = 22;
	localparam int unsigned BASE_W   = 24;

	// Days from 0000-01-01 to 1970-01-01, plus one for the 1-based day of month
	localparam logic [BASE_W-1:0] EPOCH_BASE = BASE_W'(719529);

	// Reciprocal of 100: (y * RECIP_100) >> RECIP_SHIFT == y / 100 for y < 43699
	localparam logic [12:0] RECIP_100   = 13'd5243;
	localparam int unsigned RECIP_SHIFT = 19;

	// Digit counts per field
	localparam logic [FD_W-1:0] YEAR_DIGITS = FD_W'(4);
	localparam logic [FD_W-1:0] TWO_DIGITS  = FD_W'(2);
	localparam logic [FD_W-1:0] FRAC_MAX    = FD_W'(9);
	localparam logic [FD_W-1:0] FRAC_KEEP   = FD_W'(3);

	// ASCII codes
	localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
	localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
	localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
	localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_UT    = 8'h54;
	localparam logic [CHAR_W-1:0] CH_LT    = 8'h74;
	localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
	localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;

	// Days in the year before the first of the month (non-leap)
	function automatic logic [8:0] cum_days(input logic [ACC_W-1:0] month);
		logic [8:0] d;
		case (month)
			7'd1:    d = 9'd0;
			7'd2:    d = 9'd31;
			7'd3:    d = 9'd59;
			7'd4:    d = 9'd90;
			7'd5:    d = 9'd120;
			7'd6:    d = 9'd151;
			7'd7:    d = 9'd181;
			7'd8:    d = 9'd212;
			7'd9:    d = 9'd243;
			7'd10:   d = 9'd273;
			7'd11:   d = 9'd304;
			7'd12:   d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

	// Length of the month; zero for a month that does not exist
	function automatic logic [4:0] month_len(input logic [ACC_W-1:0] month, input logic leap);
		logic [4:0] d;
		case (month)
			7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: d = 5'd31;
			7'd4, 7'd6, 7'd9, 7'd11:                   d = 5'd30;
			7'd2:    d = leap ? 5'd29 : 5'd28;
			default: d = 5'd0;
		endcase
		return d;
	endfunction

endpackage

// ===== src/iso8601_instant_parser_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iso8601_instant_parser_unit: streaming ISO-8601 timestamp parser
// Takes text one byte per request; on the last byte returns a valid flag,
// days since 1970-01-01 and milliseconds of day.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  request | req_valid/req_ready  | char_byte[7:0], last
//  result  | res_valid/res_ready  | valid_res, day_number[22:0], millis_of_day
//
//  One byte is taken per cycle while req_ready is high; a result is registered
//  as its last byte is taken. Calendar terms (year / 100, leap, year days, month
//  offset, hour-minute millis) are worked out on the separator and digit
//  bytes that follow each field, so the last byte needs only short adds.
//  arst_n clears the parser state and the output register.
//  req_ready drops only while a result is held and res_ready is low.
// ----------------------------------------------------------------------------
module iso8601_instant_parser_unit #(
	parameter int unsigned MAX_LEN = 40
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  logic [iip_pkg::CHAR_W-1:0]    char_byte,
	input  logic                          last,
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic                          valid_res,
	output logic signed [iip_pkg::DAY_W-1:0] day_number,
	output logic [iip_pkg::MS_W-1:0]      millis_of_day
);
	import iip_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAX_LEN + 1);

	typedef enum logic [3:0] {
		PH_YEAR, PH_DASH1, PH_MONTH, PH_DASH2, PH_DAY, PH_DATE_END, PH_HOUR,
		PH_COLON1, PH_MINUTE, PH_COLON2, PH_SECOND, PH_SEC_END, PH_FRAC, PH_ZULU
	} phase_t;

	// Parser state
	phase_t              phase_q;
	logic [CNT_W-1:0]    count_q;
	logic [FD_W-1:0]     fd_q;
	logic [YEAR_W-1:0]   year_q;
	logic [ACC_W-1:0]    month_q, day_q, hour_q, minute_q, second_q;
	logic [MILLI_W-1:0]  milli_q;
	logic                failed_q;

	// Calendar terms prepared while the string streams in
	logic [YEAR_W-1:0]   q100_q;
	logic                r100nz_q;
	logic                leap_q;
	logic [YDAYS_W-1:0]  ydays_q;
	logic [BASE_W-1:0]   base_q;
	logic [4:0]          lim_q;
	logic [MS_W-1:0]     hm_ms_q;

	// Next state
	phase_t              nx_phase;
	logic [CNT_W-1:0]    nx_count;
	logic [FD_W-1:0]     nx_fd;
	logic [YEAR_W-1:0]   nx_year;
	logic [ACC_W-1:0]    nx_month, nx_day, nx_hour, nx_minute, nx_second;
	logic [MILLI_W-1:0]  nx_milli;
	logic                nx_failed;

	logic                accept;
	logic                dig, zee;
	logic [3:0]          dv;
	logic [FD_W-1:0]     fd_inc;

	assign req_ready = !res_valid || res_ready;
	assign accept    = req_valid && req_ready;

	assign dig    = (char_byte >= CH_0) && (char_byte <= CH_9);
	assign dv     = dig ? char_byte[3:0] : 4'd0;
	assign zee    = (char_byte == CH_UZ) || (char_byte == CH_LZ);
	assign fd_inc = fd_q + FD_W'(1);

	// Grammar step for one byte
	always_comb begin
		nx_phase  = phase_q;
		nx_count  = count_q;
		nx_fd     = fd_q;
		nx_year   = year_q;
		nx_month  = month_q;
		nx_day    = day_q;
		nx_hour   = hour_q;
		nx_minute = minute_q;
		nx_second = second_q;
		nx_milli  = milli_q;
		nx_failed = failed_q;
		if (count_q == CNT_W'(MAX_LEN)) begin
			nx_failed = 1'b1;
		end else begin
			nx_count = count_q + CNT_W'(1);
			if (!failed_q) begin
				case (phase_q)
					PH_YEAR: begin
						if (dig) begin
							nx_year = YEAR_W'(year_q * YEAR_W'(10) + YEAR_W'(dv));
							nx_fd   = fd_inc;
							if (fd_inc >= YEAR_DIGITS) begin
								nx_fd    = '0;
								nx_phase = PH_DASH1;
							end
						end else nx_failed = 1'b1;
					end
					PH_DASH1: begin
						if (char_byte == CH_DASH) nx_phase = PH_MONTH;
						else nx_failed = 1'b1;
					end
					PH_DASH2: begin
						if (char_byte == CH_DASH) nx_phase = PH_DAY;
						else nx_failed = 1'b1;
					end
					PH_MONTH, PH_DAY, PH_HOUR, PH_MINUTE, PH_SECOND: begin
						if (dig) begin
							nx_fd = fd_inc;
							case (phase_q)
								PH_MONTH:  nx_month  = ACC_W'(month_q * ACC_W'(10) + ACC_W'(dv));
								PH_DAY:    nx_day    = ACC_W'(day_q * ACC_W'(10) + ACC_W'(dv));
								PH_HOUR:   nx_hour   = ACC_W'(hour_q * ACC_W'(10) + ACC_W'(dv));
								PH_MINUTE: nx_minute = ACC_W'(minute_q * ACC_W'(10) + ACC_W'(dv));
								default:   nx_second = ACC_W'(second_q * ACC_W'(10) + ACC_W'(dv));
							endcase
							if (fd_inc >= TWO_DIGITS) begin
								nx_fd    = '0;
								nx_phase = phase_t'(phase_q + 4'd1);
							end
						end else nx_failed = 1'b1;
					end
					PH_DATE_END: begin
						if (char_byte == CH_UT || char_byte == CH_LT || char_byte == CH_SPACE)
							nx_phase = PH_HOUR;
						else nx_failed = 1'b1;
					end
					PH_COLON1: begin
						if (char_byte == CH_COLON) nx_phase = PH_MINUTE;
						else nx_failed = 1'b1;
					end
					PH_COLON2: begin
						if (char_byte == CH_COLON) nx_phase = PH_SECOND;
						else nx_failed = 1'b1;
					end
					PH_SEC_END: begin
						if (char_byte == CH_DOT) begin
							nx_phase = PH_FRAC;
							nx_fd    = '0;
						end else if (zee) nx_phase = PH_ZULU;
						else nx_failed = 1'b1;
					end
					PH_FRAC: begin
						if (dig) begin
							if (fd_q >= FRAC_MAX) begin
								nx_failed = 1'b1;
							end else begin
								if (fd_q < FRAC_KEEP)
									nx_milli = MILLI_W'(milli_q * MILLI_W'(10) + MILLI_W'(dv));
								nx_fd = fd_inc;
							end
						end else if (zee && fd_q != '0) nx_phase = PH_ZULU;
						else nx_failed = 1'b1;
					end
					default: nx_failed = 1'b1;
				endcase
			end
		end
	end

	// Result from the state after the last byte
	logic                phase_ok, date_ok, time_ok, ok;
	logic                is_frac;
	logic [MS_W-1:0]     milli_sc;
	logic [MS_W-1:0]     ms_sum;
	logic [BASE_W-1:0]   day_sum;

	always_comb begin
		phase_ok = (nx_phase == PH_DATE_END) || (nx_phase == PH_SEC_END) ||
			(nx_phase == PH_ZULU) || ((nx_phase == PH_FRAC) && (nx_fd != '0));
		date_ok  = (nx_month >= 7'd1) && (nx_month <= 7'd12) && (nx_day != '0) &&
			(nx_day <= ACC_W'(lim_q));
		time_ok  = (nx_phase == PH_DATE_END) ||
			((nx_hour <= 7'd23) && (nx_minute <= 7'd59) && (nx_second <= 7'd59));
		ok       = !nx_failed && phase_ok && date_ok && time_ok;

		// Short fractions are padded out to three digits
		is_frac  = (nx_phase == PH_FRAC) || (nx_phase == PH_ZULU);
		milli_sc = MS_W'(nx_milli);
		if (is_frac && nx_fd == FD_W'(1))      milli_sc = MS_W'(nx_milli * 17'd100);
		else if (is_frac && nx_fd == FD_W'(2)) milli_sc = MS_W'(nx_milli * 14'd10);

		ms_sum  = hm_ms_q + MS_W'(nx_second * 17'd1000) + milli_sc;
		day_sum = base_q + BASE_W'(nx_day);
	end

	// Parser state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_YEAR;
			count_q       <= '0;
			fd_q          <= '0;
			year_q        <= '0;
			month_q       <= '0;
			day_q         <= '0;
			hour_q        <= '0;
			minute_q      <= '0;
			second_q      <= '0;
			milli_q       <= '0;
			failed_q      <= 1'b0;
			res_valid     <= 1'b0;
			valid_res     <= 1'b0;
			day_number    <= '0;
			millis_of_day <= '0;
		end else begin
			if (accept && last) res_valid <= 1'b1;
			else if (res_ready) res_valid <= 1'b0;
			if (accept) begin
				if (last) begin
					phase_q       <= PH_YEAR;
					count_q       <= '0;
					fd_q          <= '0;
					year_q        <= '0;
					month_q       <= '0;
					day_q         <= '0;
					hour_q        <= '0;
					minute_q      <= '0;
					second_q      <= '0;
					milli_q       <= '0;
					failed_q      <= 1'b0;
					valid_res     <= ok;
					day_number    <= ok ? DAY_W'(day_sum) : '0;
					millis_of_day <= (ok && nx_phase != PH_DATE_END) ? ms_sum : '0;
				end else begin
					phase_q  <= nx_phase;
					count_q  <= nx_count;
					fd_q     <= nx_fd;
					year_q   <= nx_year;
					month_q  <= nx_month;
					day_q    <= nx_day;
					hour_q   <= nx_hour;
					minute_q <= nx_minute;
					second_q <= nx_second;
					milli_q  <= nx_milli;
					failed_q <= nx_failed;
				end
			end
		end
	end

	// Calendar terms, one step per byte once each field is complete
	logic [YEAR_W-1:0]  c100;
	logic [26:0]        q100_prod;
	logic [YDAYS_W-1:0] ydays_nx;
	logic [BASE_W-1:0]  base_nx;
	logic [12:0]        hm_min;

	always_comb begin
		q100_prod = year_q * RECIP_100;
		c100      = q100_q + YEAR_W'(r100nz_q);
		ydays_nx  = YDAYS_W'(year_q * YDAYS_W'(365)) + YDAYS_W'((year_q + YEAR_W'(3)) >> 2)
			- YDAYS_W'(c100) + YDAYS_W'((c100 + YEAR_W'(3)) >> 2);
		base_nx   = BASE_W'(ydays_q) + BASE_W'(cum_days(month_q))
			+ BASE_W'(leap_q && (month_q > 7'd2)) - EPOCH_BASE;
		hm_min    = 13'(hour_q * 13'd60) + 13'(minute_q);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			case (phase_q)
				PH_DASH1: q100_q <= YEAR_W'(q100_prod >> RECIP_SHIFT);
				PH_MONTH: begin
					if (fd_q == '0) begin
						r100nz_q <= (year_q != YEAR_W'(q100_q * YEAR_W'(100)));
						leap_q   <= (year_q[1:0] == 2'd0) &&
							((year_q != YEAR_W'(q100_q * YEAR_W'(100))) || (q100_q[1:0] == 2'd0));
					end else begin
						ydays_q <= ydays_nx;
					end
				end
				PH_DASH2: begin
					base_q <= base_nx;
					lim_q  <= month_len(month_q, leap_q);
				end
				PH_COLON2: hm_ms_q <= MS_W'(hm_min * 29'd60000);
				default: ;
			endcase
		end
	end

endmodule
